>>> rtl/ssh_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssh_pkg
// Shared types and constants for the stepper axis stream and homing block.
// ----------------------------------------------------------------------------
package ssh_pkg;

  localparam int unsigned DEBOUNCE_SAMPLES_DEF = 3;
  localparam logic [2:0]  SLOT_DISENGAGED = 3'd4;
  localparam logic [31:0] TICK_MAX = 32'h0000_FFFF;

  // request codes
  localparam logic [1:0] REQ_STREAM = 2'd0;
  localparam logic [1:0] REQ_TICK   = 2'd1;
  localparam logic [1:0] REQ_ARM    = 2'd2;
  localparam logic [1:0] REQ_ABORT  = 2'd3;

  // arm status codes
  localparam logic [1:0] ARM_OK       = 2'd0;
  localparam logic [1:0] ARM_BUSY     = 2'd1;
  localparam logic [1:0] ARM_BAD_ARG  = 2'd2;
  localparam logic [1:0] ARM_MISMATCH = 2'd3;

  // config register indexes
  localparam logic [1:0] CFG_SLOT    = 2'd0;
  localparam logic [1:0] CFG_LATCH   = 2'd1;
  localparam logic [1:0] CFG_TICKS   = 2'd2;

  localparam logic [31:0] LATCH_RUN_RST = 32'd45454;
  localparam logic [7:0]  TICKS_RST = 8'd3;

  // controller to datapath commands
  typedef struct packed {
    logic load;     // capture input word
    logic exec;     // apply update for stream/tick/abort and rejected arm
    logic arm;      // commit homing arm (after divide)
    logic div_start;
    logic out_load; // capture result word
  } ssh_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic [1:0] req;
    logic       arm_ok;  // checks pass, divide needed
    logic       div_done;
  } ssh_sts_t;

endpackage
`default_nettype wire

>>> rtl/ssh_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssh_ctrl
// Sequencer: takes a word, runs the update (and the ramp divide on arm),
// then presents the result word.
// ----------------------------------------------------------------------------
module ssh_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output ssh_pkg::ssh_cmd_t    cmd,
  input  wire ssh_pkg::ssh_sts_t sts
);

  typedef enum logic [2:0] {S_IDLE, S_EXEC, S_DIV, S_DIVW, S_OUT} state_t;
  state_t state_r;
  logic   out_valid_r;

  assign out_valid = out_valid_r;
  // new word only when idle and no result waiting
  assign in_stall = (state_r != S_IDLE) || out_valid_r;

  always_comb begin
    cmd = '0;
    cmd.load = (state_r == S_IDLE) && in_valid && !out_valid_r;
    unique case (state_r)
      S_IDLE: ;
      S_EXEC: begin
        if (sts.req == ssh_pkg::REQ_ARM && sts.arm_ok) cmd.div_start = 1'b1;
        else begin
          cmd.exec = 1'b1;
          cmd.out_load = 1'b1;
        end
      end
      S_DIV:  ;
      S_DIVW: begin
        if (sts.div_done) begin
          cmd.arm = 1'b1;
          cmd.out_load = 1'b1;
        end
      end
      S_OUT:  ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: if (cmd.load) state_r <= S_EXEC;
        S_EXEC: begin
          if (cmd.div_start) state_r <= S_DIV;
          else begin
            state_r <= S_IDLE;
            out_valid_r <= 1'b1;
          end
        end
        S_DIV:  state_r <= S_DIVW;
        S_DIVW: if (sts.div_done) begin
          state_r <= S_IDLE;
          out_valid_r <= 1'b1;
        end
        S_OUT:  state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> rtl/ssh_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssh_dp
// Datapath: axis state, stream and tick updates, arm checks, a 16-step
// restoring divider for the ramp decrement, and the result register.
// ----------------------------------------------------------------------------
module ssh_dp #(
  parameter int unsigned DEBOUNCE_SAMPLES = ssh_pkg::DEBOUNCE_SAMPLES_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire ssh_pkg::ssh_cmd_t  cmd,
  output ssh_pkg::ssh_sts_t       sts,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_idx,
  input  wire logic [31:0]        cfg_data,
  input  wire logic [1:0]         in_req_type,
  input  wire logic [7:0]         in_stream_byte,
  input  wire logic               in_limit_level,
  input  wire logic               in_home_dir,
  input  wire logic               in_home_retract_intent,
  input  wire logic [15:0]        in_start_us,
  input  wire logic [15:0]        in_floor_us,
  input  wire logic [15:0]        in_ramp_steps,
  input  wire logic [31:0]        in_step_budget,
  output logic                    out_step_out,
  output logic                    out_dir_out,
  output logic signed [31:0]      out_axis_position,
  output logic                    out_homing_busy,
  output logic                    out_limit_flag,
  output logic signed [31:0]      out_leg_span,
  output logic [1:0]              out_arm_status,
  output logic [15:0]             out_interval_ticks
);

  // config
  logic [2:0]  slot_r;
  logic [31:0] latch_run_r;
  logic [7:0]  tpu_r;

  // captured word
  logic [1:0]  req_r;
  logic [7:0]  byte_r;
  logic        lim_r, hdir_r, intent_r;
  logic [15:0] su_r, fu_r, rs_r;
  logic [31:0] budget_r;

  // axis state
  logic [31:0] pos_r, tot_r, base_r, steps_r, span_start_r, span_r;
  logic        dir_r, latch_r, homing_r, mdir_r, mret_r, found_r;
  logic [15:0] cur_r, floor_r, dec_r;
  logic [1:0]  deb_r;

  // products (one 16x8 multiply each, registered)
  logic [23:0] st_r, ft_r;

  // divider
  logic [15:0] quo_r, rem_r;
  logic [4:0]  dcnt_r;

  logic [31:0] pos_nxt, tot_nxt, base_nxt, span_nxt;
  logic        dir_nxt, latch_nxt, homing_nxt, found_nxt, step_nxt;
  logic [15:0] cur_nxt;
  logic [1:0]  deb_nxt, status_nxt;
  logic [31:0] steps_nxt;
  logic        stop;
  logic        bad_arg;
  logic [16:0] trial;

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= ssh_pkg::SLOT_DISENGAGED;
      latch_run_r <= ssh_pkg::LATCH_RUN_RST;
      tpu_r <= ssh_pkg::TICKS_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        ssh_pkg::CFG_SLOT:  slot_r <= cfg_data[2:0];
        ssh_pkg::CFG_LATCH: latch_run_r <= cfg_data;
        ssh_pkg::CFG_TICKS: tpu_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // input capture and products
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= in_req_type; byte_r <= in_stream_byte; lim_r <= in_limit_level;
      hdir_r <= in_home_dir; intent_r <= in_home_retract_intent;
      su_r <= in_start_us; fu_r <= in_floor_us; rs_r <= in_ramp_steps;
      budget_r <= in_step_budget;
      st_r <= in_start_us * tpu_r;
      ft_r <= in_floor_us * tpu_r;
    end
  end

  assign bad_arg = (su_r == '0) || (fu_r == '0) || (fu_r > su_r) || (budget_r == '0)
                 || ({8'd0, st_r} > ssh_pkg::TICK_MAX) || (st_r == '0) || (ft_r == '0);

  always_comb begin
    sts.req = req_r;
    sts.arm_ok = (lim_r == intent_r) && !homing_r && !bad_arg;
    sts.div_done = (dcnt_r == '0);
  end

  // stream / tick / abort update and arm status
  always_comb begin
    pos_nxt = pos_r; tot_nxt = tot_r; base_nxt = base_r; span_nxt = span_r;
    dir_nxt = dir_r; latch_nxt = latch_r; homing_nxt = homing_r;
    found_nxt = found_r; step_nxt = 1'b0; cur_nxt = cur_r; deb_nxt = deb_r;
    steps_nxt = steps_r; status_nxt = ssh_pkg::ARM_OK; stop = 1'b0;
    unique case (req_r)
      ssh_pkg::REQ_STREAM: begin
        if (slot_r < ssh_pkg::SLOT_DISENGAGED && !homing_r) begin
          if (lim_r) begin
            tot_nxt = tot_r + 32'd1;
            if (tot_nxt - base_r >= latch_run_r) latch_nxt = 1'b1;
          end else base_nxt = tot_r;
          if (!lim_r && !latch_nxt) begin
            dir_nxt = byte_r[{slot_r[1:0], 1'b1}];
            if (byte_r[{slot_r[1:0], 1'b0}]) begin
              pos_nxt = dir_nxt ? pos_r + 32'd1 : pos_r - 32'd1;
              step_nxt = 1'b1;
            end
          end
        end
      end
      ssh_pkg::REQ_TICK: begin
        if (homing_r) begin
          if (!mret_r) begin
            if (lim_r) begin
              deb_nxt = deb_r + 2'd1;
              if (32'(deb_nxt) >= DEBOUNCE_SAMPLES) begin
                found_nxt = 1'b1;
                stop = 1'b1;
              end
            end else deb_nxt = '0;
          end
          if (!stop) begin
            if (steps_r == '0) stop = 1'b1;
            else begin
              pos_nxt = mdir_r ? pos_r + 32'd1 : pos_r - 32'd1;
              steps_nxt = steps_r - 32'd1;
              step_nxt = 1'b1;
              if (dec_r != '0 && cur_r > floor_r) begin
                if (cur_r - floor_r <= dec_r) cur_nxt = floor_r;
                else cur_nxt = cur_r - dec_r;
              end
            end
          end
        end
      end
      ssh_pkg::REQ_ARM: begin
        if (lim_r != intent_r) status_nxt = ssh_pkg::ARM_MISMATCH;
        else if (homing_r) status_nxt = ssh_pkg::ARM_BUSY;
        else if (bad_arg) status_nxt = ssh_pkg::ARM_BAD_ARG;
      end
      ssh_pkg::REQ_ABORT: stop = homing_r;
      default: ;
    endcase
    // end of homing leg
    if (stop) begin
      homing_nxt = 1'b0;
      span_nxt = pos_nxt - span_start_r;
      if (mret_r && !lim_r) begin
        latch_nxt = 1'b0;
        base_nxt = tot_nxt;
      end
      if (!mret_r && found_nxt) latch_nxt = 1'b1;
    end
  end

  // trial subtract of the ramp length from the shifted remainder
  assign trial = {rem_r, quo_r[15]} - {1'b0, rs_r};

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0; tot_r <= '0; base_r <= '0; steps_r <= '0; span_start_r <= '0;
      span_r <= '0; dir_r <= 1'b0; latch_r <= 1'b0; homing_r <= 1'b0;
      mdir_r <= 1'b0; mret_r <= 1'b0; found_r <= 1'b0; cur_r <= '0;
      floor_r <= '0; dec_r <= '0; deb_r <= '0; dcnt_r <= '0;
    end else begin
      if (cmd.exec) begin
        pos_r <= pos_nxt; tot_r <= tot_nxt; base_r <= base_nxt; span_r <= span_nxt;
        dir_r <= dir_nxt; latch_r <= latch_nxt; homing_r <= homing_nxt;
        found_r <= found_nxt; cur_r <= cur_nxt; deb_r <= deb_nxt;
        steps_r <= steps_nxt;
      end
      // restoring divide: (st - ft) / rs, one quotient bit a cycle
      if (cmd.div_start) begin
        quo_r <= 16'(st_r) - 16'(ft_r);
        rem_r <= '0;
        dcnt_r <= 5'd16;
      end else if (dcnt_r != '0) begin
        dcnt_r <= dcnt_r - 5'd1;
        if (!trial[16]) begin
          rem_r <= trial[15:0];
          quo_r <= {quo_r[14:0], 1'b1};
        end else begin
          rem_r <= {rem_r[14:0], quo_r[15]};
          quo_r <= {quo_r[14:0], 1'b0};
        end
      end
      if (cmd.arm) begin
        mdir_r <= hdir_r; mret_r <= lim_r; floor_r <= 16'(ft_r);
        steps_r <= budget_r; deb_r <= '0;
        cur_r <= (rs_r != '0) ? 16'(st_r) : 16'(ft_r);
        dec_r <= (rs_r != '0) ? quo_r : 16'd0;
        homing_r <= 1'b1; found_r <= 1'b0; span_start_r <= pos_r; dir_r <= hdir_r;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_step_out <= cmd.arm ? 1'b0 : step_nxt;
      out_dir_out <= cmd.arm ? hdir_r : dir_nxt;
      out_axis_position <= cmd.arm ? pos_r : pos_nxt;
      out_homing_busy <= cmd.arm ? 1'b1 : homing_nxt;
      out_limit_flag <= lim_r | latch_nxt;
      out_leg_span <= span_nxt;
      out_arm_status <= cmd.arm ? ssh_pkg::ARM_OK : status_nxt;
      out_interval_ticks <= cmd.arm ? ((rs_r != '0) ? 16'(st_r) : 16'(ft_r)) : cur_nxt;
    end
  end

endmodule
`default_nettype wire

>>> rtl/stepper_axis_stream_and_homing.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stepper_axis_stream_and_homing
// One stepper axis with limit switch: stream stepping and ramped homing.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one request word: a stream
//   byte, a pulser tick, a homing arm or an abort. Each word yields exactly
//   one result word on the output channel (out_valid / out_stall).
//   Config channel (cfg_valid / cfg_ready, cfg_index, cfg_data) writes the
//   slot binding, the latch run length and ticks per microsecond; it is
//   always ready and should be used only while the block is idle.
// Sequencing:
//   Stream, tick, abort and rejected arm words present their result once the
//   update is registered; an accepted arm runs the 16-step ramp divider first
//   and presents its result when the divide is done. One word is in flight
//   at a time; the next is taken the cycle after the result is delivered.
// Reset (rst_n low, synchronous): slot disengaged, latch and homing cleared,
//   position zero, config at its defaults.
// Stall: a stalled result holds; in_stall stays high until it is taken.
// ----------------------------------------------------------------------------
module stepper_axis_stream_and_homing #(
  parameter int unsigned DEBOUNCE_SAMPLES = ssh_pkg::DEBOUNCE_SAMPLES_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         in_req_type,
  input  wire logic [7:0]         in_stream_byte,
  input  wire logic               in_limit_level,
  input  wire logic               in_home_dir,
  input  wire logic               in_home_retract_intent,
  input  wire logic [15:0]        in_start_us,
  input  wire logic [15:0]        in_floor_us,
  input  wire logic [15:0]        in_ramp_steps,
  input  wire logic [31:0]        in_step_budget,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    out_step_out,
  output logic                    out_dir_out,
  output logic signed [31:0]      out_axis_position,
  output logic                    out_homing_busy,
  output logic                    out_limit_flag,
  output logic signed [31:0]      out_leg_span,
  output logic [1:0]              out_arm_status,
  output logic [15:0]             out_interval_ticks,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [31:0]        cfg_data
);

  ssh_pkg::ssh_cmd_t cmd;
  ssh_pkg::ssh_sts_t sts;

  assign cfg_ready = 1'b1;

  ssh_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall, .cmd, .sts
  );

  ssh_dp #(.DEBOUNCE_SAMPLES(DEBOUNCE_SAMPLES)) u_dp (
    .clk, .rst_n, .cmd, .sts,
    .cfg_we(cfg_valid & cfg_ready), .cfg_idx(cfg_index), .cfg_data,
    .in_req_type, .in_stream_byte, .in_limit_level, .in_home_dir,
    .in_home_retract_intent, .in_start_us, .in_floor_us, .in_ramp_steps,
    .in_step_budget, .out_step_out, .out_dir_out, .out_axis_position,
    .out_homing_busy, .out_limit_flag, .out_leg_span, .out_arm_status,
    .out_interval_ticks
  );

endmodule
`default_nettype wire

>>> rtl/ssh_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssh_checker
// Port-level checks for the stepper axis block, bound to the top level.
// ----------------------------------------------------------------------------
module ssh_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_stall,
  input wire logic out_valid,
  input wire logic out_stall,
  input wire logic out_step_out,
  input wire logic [1:0] out_arm_status,
  input wire logic out_homing_busy
);

  // result word holds while stalled
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid) else $error("result dropped");

  // no new word while a result waits
  a_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("word taken with result pending");

  // a step and an arm status never come together
  a_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_step_out |-> out_arm_status == ssh_pkg::ARM_OK)
    else $error("step with arm status");

  // a rejected-as-busy arm only happens while homing
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_arm_status == ssh_pkg::ARM_BUSY |-> out_homing_busy)
    else $error("busy status while idle");

endmodule

bind stepper_axis_stream_and_homing ssh_checker u_ssh_checker (
  .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall,
  .out_step_out, .out_arm_status, .out_homing_busy
);
`default_nettype wire
